// ===== sv/dcf_pkg.sv =====
// Shared types, codes and helper functions of the DHCP client engine.
`default_nettype none
package dcf_pkg;

    localparam logic [2:0] CMD_START   = 3'd0;
    localparam logic [2:0] CMD_STOP    = 3'd1;
    localparam logic [2:0] CMD_RELEASE = 3'd2;
    localparam logic [2:0] CMD_RX      = 3'd3;
    localparam logic [2:0] CMD_T1      = 3'd4;
    localparam logic [2:0] CMD_T2      = 3'd5;

    localparam logic [1:0] MSG_OFFER = 2'd0;
    localparam logic [1:0] MSG_ACK   = 2'd1;
    localparam logic [1:0] MSG_NAK   = 2'd2;
    localparam logic [1:0] MSG_OTHER = 2'd3;

    localparam logic [1:0] CFG_ENABLE = 2'd0;
    localparam logic [1:0] CFG_RETRY  = 2'd1;
    localparam logic [1:0] CFG_SEED   = 2'd2;

    localparam logic [2:0] ST_CODE_INIT       = 3'd0;
    localparam logic [2:0] ST_CODE_SELECTING  = 3'd1;
    localparam logic [2:0] ST_CODE_REQUESTING = 3'd2;
    localparam logic [2:0] ST_CODE_BOUND      = 3'd3;
    localparam logic [2:0] ST_CODE_RENEWING   = 3'd4;
    localparam logic [2:0] ST_CODE_RELEASING  = 3'd5;

    localparam logic [31:0] LFSR_MASK = 32'h8020_0003;

    localparam int IN_DATA_W  = 264;
    localparam int IN_USER_W  = 5;
    localparam int OUT_DATA_W = 144;

    typedef enum logic [5:0] {
        S_INIT       = 6'b000001,
        S_SELECTING  = 6'b000010,
        S_REQUESTING = 6'b000100,
        S_BOUND      = 6'b001000,
        S_RENEWING   = 6'b010000,
        S_RELEASING  = 6'b100000
    } t_state;

    typedef struct packed {
        logic [2:0]  cmd;
        logic        retain_ip;
        logic [31:0] rx_xid;
        logic [1:0]  msg_type;
        logic [31:0] your_addr;
        logic [31:0] server_addr;
        logic [31:0] server_id;
        logic [31:0] lease_len;
        logic [31:0] router_addr;
        logic        lease_ok;
        logic [31:0] t1_bind;
        logic [31:0] t2_bind;
        logic [31:0] t1_def;
        logic [31:0] t2_def;
    } t_item;

    typedef struct packed {
        logic [2:0]  state_now;
        logic        send_request;
        logic        send_arp;
        logic [31:0] ip_addr;
        logic [31:0] gateway_addr;
        logic        arm_renew;
        logic        arm_rebind;
        logic [31:0] renew_secs;
        logic [31:0] rebind_secs;
        logic        cancel_timers;
        logic        established;
        logic        restarted;
    } t_result;

    function automatic logic [31:0] lfsr_next(input logic [31:0] v);
        logic [31:0] s;
        s = {1'b0, v[31:1]};
        if (v[0]) begin
            s = s ^ LFSR_MASK;
        end
        return s;
    endfunction

    function automatic logic [2:0] state_code(input t_state s);
        logic [2:0] c;
        case (s)
            S_INIT:       c = ST_CODE_INIT;
            S_SELECTING:  c = ST_CODE_SELECTING;
            S_REQUESTING: c = ST_CODE_REQUESTING;
            S_BOUND:      c = ST_CODE_BOUND;
            S_RENEWING:   c = ST_CODE_RENEWING;
            S_RELEASING:  c = ST_CODE_RELEASING;
            default:      c = ST_CODE_INIT;
        endcase
        return c;
    endfunction

endpackage
`default_nettype wire

// ===== sv/dcf_front.sv =====
// Front end: accepts input beats, precomputes lease checks and timer defaults.
`default_nettype none
module dcf_front (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           s_axis_tvalid,
    output logic                                s_axis_tready,
    input  wire logic [dcf_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    input  wire logic [dcf_pkg::IN_USER_W-1:0]  s_axis_tuser,
    output logic                                o_push_valid,
    input  wire logic                           i_push_ready,
    output dcf_pkg::t_item                      o_push_item
);

    logic           r_valid;
    dcf_pkg::t_item r_item;
    dcf_pkg::t_item n_item;

    logic [31:0] w_lease;
    logic [1:0]  w_flags;
    logic [31:0] w_t1;
    logic [31:0] w_t2;
    logic [34:0] w_seven;
    logic [31:0] w_def1;
    logic [31:0] w_def2;

    assign s_axis_tready = !r_valid || i_push_ready;

    always_comb begin
        w_lease = s_axis_tdata[160:129];
        w_flags = s_axis_tdata[194:193];
        w_t1    = s_axis_tdata[226:195];
        w_t2    = s_axis_tdata[258:227];
        w_seven = {w_lease, 3'b000} - {3'b000, w_lease};
        w_def1  = {1'b0, w_lease[31:1]};
        w_def2  = w_seven[34:3];
        if (w_def1 == 32'd0) begin
            w_def1 = 32'd1;
        end
        if (w_def2 == 32'd0) begin
            w_def2 = 32'd1;
        end

        n_item.cmd          = s_axis_tuser[2:0];
        n_item.msg_type     = s_axis_tuser[4:3];
        n_item.retain_ip    = s_axis_tdata[0];
        n_item.rx_xid       = s_axis_tdata[32:1];
        n_item.your_addr    = s_axis_tdata[64:33];
        n_item.server_addr  = s_axis_tdata[96:65];
        n_item.server_id    = s_axis_tdata[128:97];
        n_item.lease_len    = w_lease;
        n_item.router_addr  = s_axis_tdata[192:161];
        n_item.lease_ok     = (s_axis_tdata[64:33] != 32'd0)
                           && (s_axis_tdata[128:97] != 32'd0) && (w_lease != 32'd0);
        n_item.t1_def       = w_def1;
        n_item.t2_def       = w_def2;
        n_item.t1_bind      = w_flags[0] ? ((w_t1 != 32'd0) ? w_t1 : 32'd1) : w_def1;
        n_item.t2_bind      = w_flags[1] ? ((w_t2 != 32'd0) ? w_t2 : 32'd1) : w_def2;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_valid <= s_axis_tvalid;
        end
        if (s_axis_tvalid && s_axis_tready) begin
            r_item <= n_item;
        end
    end

    assign o_push_valid = r_valid;
    assign o_push_item  = r_item;

endmodule
`default_nettype wire

// ===== sv/dcf_queue.sv =====
// Two-entry queue between the front end and the execution back end.
`default_nettype none
module dcf_queue (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push_valid,
    output logic                o_push_ready,
    input  wire dcf_pkg::t_item i_push_item,
    output logic                o_pop_valid,
    input  wire logic           i_pop,
    output dcf_pkg::t_item      o_pop_item
);

    dcf_pkg::t_item r_entry [2];
    logic           r_wr_ptr;
    logic           r_rd_ptr;
    logic [1:0]     r_count;
    logic           w_push;
    logic           w_pop;

    assign o_push_ready = (r_count != 2'd2);
    assign o_pop_valid  = (r_count != 2'd0);
    assign o_pop_item   = r_entry[r_rd_ptr];
    assign w_push       = i_push_valid && o_push_ready;
    assign w_pop        = i_pop && o_pop_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (w_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            case ({w_push, w_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
        if (w_push) begin
            r_entry[r_wr_ptr] <= i_push_item;
        end
    end

endmodule
`default_nettype wire

// ===== sv/dcf_back.sv =====
// Back end: client state machine, lease registers and registered result beat.
`default_nettype none
module dcf_back (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_pop_valid,
    output logic                                o_pop,
    input  wire dcf_pkg::t_item                 i_item,
    input  wire logic                           i_cfg_fire,
    input  wire logic [1:0]                     i_cfg_index,
    input  wire logic [31:0]                    i_cfg_data,
    output logic                                m_axis_tvalid,
    input  wire logic                           m_axis_tready,
    output logic [dcf_pkg::OUT_DATA_W-1:0]      m_axis_tdata
);

    dcf_pkg::t_state r_state, n_state;
    logic [31:0] r_lfsr, n_lfsr;
    logic [31:0] r_leased, n_leased;
    logic [31:0] r_server_field, n_server_field;
    logic [31:0] r_server_ident, n_server_ident;
    logic [31:0] r_lease, n_lease;
    logic [31:0] r_bound_ip, n_bound_ip;
    logic [31:0] r_gateway, n_gateway;
    logic [31:0] r_renew, n_renew;
    logic [31:0] r_rebind, n_rebind;
    logic        r_requested, n_requested;
    logic        r_bound_flag, n_bound_flag;
    logic        r_enabled, n_enabled;
    logic        r_retry, n_retry;
    logic        r_out_valid;
    dcf_pkg::t_result r_out, n_out;

    logic go_stop, go_keep, go_restart, go_store;

    assign o_pop = i_pop_valid && (!r_out_valid || m_axis_tready);

    always_comb begin
        n_state        = r_state;
        n_lfsr         = r_lfsr;
        n_leased       = r_leased;
        n_server_field = r_server_field;
        n_server_ident = r_server_ident;
        n_lease        = r_lease;
        n_bound_ip     = r_bound_ip;
        n_gateway      = r_gateway;
        n_renew        = r_renew;
        n_rebind       = r_rebind;
        n_requested    = r_requested;
        n_bound_flag   = r_bound_flag;
        n_enabled      = r_enabled;
        n_retry        = r_retry;
        n_out          = '0;
        go_stop        = 1'b0;
        go_keep        = 1'b0;
        go_restart     = 1'b0;
        go_store       = 1'b0;

        if (o_pop && r_enabled) begin
            case (i_item.cmd)
                dcf_pkg::CMD_START: begin
                    if (!r_requested) begin
                        n_requested = 1'b1;
                        n_state = (r_leased != 32'd0) ? dcf_pkg::S_REQUESTING
                                                      : dcf_pkg::S_SELECTING;
                        n_lfsr = dcf_pkg::lfsr_next(r_lfsr);
                        n_out.send_request = 1'b1;
                    end
                end
                dcf_pkg::CMD_STOP: begin
                    go_stop = 1'b1;
                    go_keep = i_item.retain_ip;
                end
                dcf_pkg::CMD_RELEASE: begin
                    if (r_state == dcf_pkg::S_SELECTING) begin
                        go_stop = 1'b1;
                    end else if (r_state == dcf_pkg::S_REQUESTING
                              || r_state == dcf_pkg::S_BOUND
                              || r_state == dcf_pkg::S_RENEWING) begin
                        if (!r_retry) begin
                            go_stop = 1'b1;
                        end else begin
                            n_state = dcf_pkg::S_RELEASING;
                            n_lfsr = dcf_pkg::lfsr_next(r_lfsr);
                            n_out.send_request = 1'b1;
                        end
                    end
                end
                dcf_pkg::CMD_RX: begin
                    if (r_state != dcf_pkg::S_INIT && i_item.rx_xid == r_lfsr
                        && i_item.msg_type != dcf_pkg::MSG_OTHER) begin
                        case (r_state)
                            dcf_pkg::S_SELECTING: begin
                                if (i_item.msg_type == dcf_pkg::MSG_OFFER) begin
                                    go_store = 1'b1;
                                    if (!i_item.lease_ok) begin
                                        go_restart = 1'b1;
                                    end else begin
                                        n_state = dcf_pkg::S_REQUESTING;
                                        n_out.arm_rebind = 1'b1;
                                        n_out.rebind_secs = i_item.lease_len;
                                        n_out.send_request = 1'b1;
                                    end
                                end
                            end
                            dcf_pkg::S_REQUESTING: begin
                                if (i_item.msg_type == dcf_pkg::MSG_ACK) begin
                                    go_store = 1'b1;
                                    if (!i_item.lease_ok
                                        || i_item.router_addr == 32'd0) begin
                                        go_restart = 1'b1;
                                    end else begin
                                        n_bound_ip   = i_item.your_addr;
                                        n_gateway    = i_item.router_addr;
                                        n_renew      = i_item.t1_bind;
                                        n_rebind     = i_item.t2_bind;
                                        n_bound_flag = 1'b1;
                                        n_state      = dcf_pkg::S_BOUND;
                                        n_out.arm_renew   = 1'b1;
                                        n_out.arm_rebind  = 1'b1;
                                        n_out.renew_secs  = i_item.t1_bind;
                                        n_out.rebind_secs = i_item.t2_bind;
                                        n_out.send_arp    = 1'b1;
                                    end
                                end else if (i_item.msg_type == dcf_pkg::MSG_NAK) begin
                                    go_restart = 1'b1;
                                end
                            end
                            dcf_pkg::S_RENEWING: begin
                                if (i_item.msg_type == dcf_pkg::MSG_ACK) begin
                                    go_store = 1'b1;
                                    if (!i_item.lease_ok) begin
                                        go_restart = 1'b1;
                                    end else begin
                                        n_state  = dcf_pkg::S_BOUND;
                                        n_renew  = i_item.t1_def;
                                        n_rebind = i_item.t2_def;
                                        n_out.arm_renew   = 1'b1;
                                        n_out.arm_rebind  = 1'b1;
                                        n_out.renew_secs  = i_item.t1_def;
                                        n_out.rebind_secs = i_item.t2_def;
                                        n_out.send_arp    = 1'b1;
                                    end
                                end else if (i_item.msg_type == dcf_pkg::MSG_NAK) begin
                                    go_restart = 1'b1;
                                end
                            end
                            dcf_pkg::S_RELEASING: begin
                                n_state = dcf_pkg::S_INIT;
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                dcf_pkg::CMD_T1: begin
                    if (r_state == dcf_pkg::S_BOUND) begin
                        n_lfsr = dcf_pkg::lfsr_next(r_lfsr);
                        n_state = dcf_pkg::S_RENEWING;
                        n_out.send_request = 1'b1;
                    end
                end
                dcf_pkg::CMD_T2: begin
                    go_restart = 1'b1;
                end
                default: begin
                end
            endcase
        end

        if (go_store) begin
            n_leased       = i_item.your_addr;
            n_server_field = i_item.server_addr;
            n_server_ident = i_item.server_id;
            n_lease        = i_item.lease_len;
        end

        if (go_stop || go_restart) begin
            n_state        = dcf_pkg::S_INIT;
            n_bound_ip     = 32'd0;
            n_gateway      = 32'd0;
            n_out.cancel_timers = 1'b1;
            if (!go_keep) begin
                n_leased = 32'd0;
            end
            n_lease        = 32'd0;
            n_renew        = 32'd0;
            n_rebind       = 32'd0;
            n_server_field = 32'd0;
            n_server_ident = 32'd0;
            n_bound_flag   = 1'b0;
            n_requested    = 1'b0;
        end

        if (go_restart) begin
            n_requested = 1'b1;
            n_state     = dcf_pkg::S_SELECTING;
            n_lfsr      = dcf_pkg::lfsr_next(r_lfsr);
            n_out.send_request = 1'b1;
            n_out.restarted    = 1'b1;
        end

        n_out.state_now    = dcf_pkg::state_code(n_state);
        n_out.ip_addr      = n_bound_ip;
        n_out.gateway_addr = n_gateway;
        n_out.established  = n_bound_flag;

        if (i_cfg_fire) begin
            case (i_cfg_index)
                dcf_pkg::CFG_ENABLE: n_enabled = i_cfg_data[0];
                dcf_pkg::CFG_RETRY:  n_retry   = i_cfg_data[0];
                dcf_pkg::CFG_SEED:   n_lfsr    = (i_cfg_data != 32'd0) ? i_cfg_data : 32'd1;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= dcf_pkg::S_INIT;
            r_lfsr         <= 32'd1;
            r_leased       <= 32'd0;
            r_server_field <= 32'd0;
            r_server_ident <= 32'd0;
            r_lease        <= 32'd0;
            r_bound_ip     <= 32'd0;
            r_gateway      <= 32'd0;
            r_renew        <= 32'd0;
            r_rebind       <= 32'd0;
            r_requested    <= 1'b0;
            r_bound_flag   <= 1'b0;
            r_enabled      <= 1'b1;
            r_retry        <= 1'b0;
            r_out_valid    <= 1'b0;
        end else begin
            r_state        <= n_state;
            r_lfsr         <= n_lfsr;
            r_leased       <= n_leased;
            r_server_field <= n_server_field;
            r_server_ident <= n_server_ident;
            r_lease        <= n_lease;
            r_bound_ip     <= n_bound_ip;
            r_gateway      <= n_gateway;
            r_renew        <= n_renew;
            r_rebind       <= n_rebind;
            r_requested    <= n_requested;
            r_bound_flag   <= n_bound_flag;
            r_enabled      <= n_enabled;
            r_retry        <= n_retry;
            if (o_pop) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
        if (o_pop) begin
            r_out <= n_out;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {6'd0, r_out.restarted, r_out.established, r_out.cancel_timers,
                            r_out.rebind_secs, r_out.renew_secs, r_out.arm_rebind,
                            r_out.arm_renew, r_out.gateway_addr, r_out.ip_addr,
                            r_out.send_arp, r_out.send_request, r_out.state_now};

endmodule
`default_nettype wire

// ===== sv/dhcp_client_fsm_core.sv =====
// An accepted input beat passes the front register, the queue and the output register to its result beat.
// Throughput: one beat per cycle while neither side stalls; front register, 2-entry queue and output register
// let each side stall independently, and the back end retires one event per cycle while its output register is free.
// Reset (i_rst_n low, synchronous): state init, xid generator 1, lease cleared,
// DHCP enabled, release retry off, queue and output empty.
`default_nettype none
module dhcp_client_fsm_core (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    // retain_ip, rx_xid, your_addr, server_addr, server_id, lease_len,
    // router_addr, option_flags, t1_time, t2_time, zero pad
    input  wire logic [263:0] s_axis_tdata,
    // cmd, msg_type
    input  wire logic [4:0]   s_axis_tuser,
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    // state_now, send_request, send_arp, ip_addr, gateway_addr, arm_renew,
    // arm_rebind, renew_secs, rebind_secs, cancel_timers, established,
    // restarted, zero pad
    output logic [143:0]      m_axis_tdata,
    input  wire logic         i_cfg_valid,
    output logic              o_cfg_ready,
    input  wire logic [1:0]   i_cfg_index,
    input  wire logic [31:0]  i_cfg_data
);

    logic           w_push_valid;
    logic           w_push_ready;
    dcf_pkg::t_item w_push_item;
    logic           w_pop_valid;
    logic           w_pop;
    dcf_pkg::t_item w_pop_item;

    assign o_cfg_ready = 1'b1;

    dcf_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .o_push_valid  (w_push_valid),
        .i_push_ready  (w_push_ready),
        .o_push_item   (w_push_item)
    );

    dcf_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (w_push_valid),
        .o_push_ready (w_push_ready),
        .i_push_item  (w_push_item),
        .o_pop_valid  (w_pop_valid),
        .i_pop        (w_pop),
        .o_pop_item   (w_pop_item)
    );

    dcf_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_pop_valid   (w_pop_valid),
        .o_pop         (w_pop),
        .i_item        (w_pop_item),
        .i_cfg_fire    (i_cfg_valid && o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

endmodule
`default_nettype wire

// ===== tb/sv/tb_dhcp_client_fsm_core.sv =====
// Self-checking testbench for the DHCP client engine: predicts every status beat from the event stream.
`timescale 1ns / 1ps
module tb_dhcp_client_fsm_core;

    localparam int RESET_CYCLES   = 8;
    localparam int RX_HOLD_CYCLES = 300;
    localparam int TAIL_CYCLES    = 12;
    localparam int CYCLE_LIMIT    = 400000;
    localparam logic [2:0] CMD_SPARE_6 = 3'd6;
    localparam logic [2:0] CMD_SPARE_7 = 3'd7;

    typedef struct packed {
        logic [2:0]  cmd;
        logic        keep;
        logic [31:0] rx_xid;
        logic [1:0]  msg_type;
        logic [31:0] your_addr;
        logic [31:0] server_addr;
        logic [31:0] server_id;
        logic [31:0] lease_len;
        logic [31:0] router_addr;
        logic [1:0]  opt_flags;
        logic [31:0] t1_time;
        logic [31:0] t2_time;
    } t_event;

    class t_lease_tracker;
        bit               enabled;
        bit               retry_release;
        logic [2:0]       st;
        logic [31:0]      xid;
        logic [31:0]      leased;
        logic [31:0]      srv_field;
        logic [31:0]      srv_ident;
        logic [31:0]      lease;
        logic [31:0]      ip;
        logic [31:0]      gw;
        logic [31:0]      t1;
        logic [31:0]      t2;
        bit               requested;
        bit               bound;
        dcf_pkg::t_result nxt;
        dcf_pkg::t_result status_due[$];
        int               mismatches;

        function new();
            enabled = 1'b1;
            retry_release = 1'b0;
            st = dcf_pkg::ST_CODE_INIT;
            xid = 32'd1;
            leased = '0;
            srv_field = '0;
            srv_ident = '0;
            lease = '0;
            ip = '0;
            gw = '0;
            t1 = '0;
            t2 = '0;
            requested = 1'b0;
            bound = 1'b0;
            mismatches = 0;
        endfunction

        function void write_reg(logic [1:0] idx, logic [31:0] val);
            case (idx)
                dcf_pkg::CFG_ENABLE: enabled = val[0];
                dcf_pkg::CFG_RETRY:  retry_release = val[0];
                dcf_pkg::CFG_SEED:   xid = (val == 32'd0) ? 32'd1 : val;
                default: ;
            endcase
        endfunction

        function void advance_xid();
            xid = {1'b0, xid[31:1]} ^ (xid[0] ? dcf_pkg::LFSR_MASK : 32'd0);
        endfunction

        function void stop(logic keep);
            st = dcf_pkg::ST_CODE_INIT;
            ip = '0;
            gw = '0;
            nxt.cancel_timers = 1'b1;
            if (!keep) leased = '0;
            lease = '0;
            t1 = '0;
            t2 = '0;
            srv_field = '0;
            srv_ident = '0;
            bound = 1'b0;
            requested = 1'b0;
        endfunction

        function void start();
            if (requested) return;
            requested = 1'b1;
            st = (leased != 32'd0) ? dcf_pkg::ST_CODE_REQUESTING : dcf_pkg::ST_CODE_SELECTING;
            advance_xid();
            nxt.send_request = 1'b1;
        endfunction

        function void restart();
            stop(1'b0);
            start();
            nxt.restarted = 1'b1;
        endfunction

        function bit take_lease(t_event ev);
            leased = ev.your_addr;
            srv_field = ev.server_addr;
            srv_ident = ev.server_id;
            lease = ev.lease_len;
            return leased != 32'd0 && srv_ident != 32'd0 && lease != 32'd0;
        endfunction

        function logic [31:0] half_lease();
            logic [31:0] v;
            v = lease >> 1;
            return (v == 32'd0) ? 32'd1 : v;
        endfunction

        function logic [31:0] seven_eighths_lease();
            logic [34:0] p;
            p = {3'd0, lease} * 35'd7;
            return (p[34:3] == 32'd0) ? 32'd1 : p[34:3];
        endfunction

        function void arm_both();
            nxt.arm_renew = 1'b1;
            nxt.renew_secs = t1;
            nxt.arm_rebind = 1'b1;
            nxt.rebind_secs = t2;
            nxt.send_arp = 1'b1;
        endfunction

        function void receive(t_event ev);
            if (st == dcf_pkg::ST_CODE_INIT || ev.rx_xid != xid
                || ev.msg_type == dcf_pkg::MSG_OTHER) return;
            case (st)
                dcf_pkg::ST_CODE_SELECTING: begin
                    if (ev.msg_type == dcf_pkg::MSG_OFFER) begin
                        st = dcf_pkg::ST_CODE_REQUESTING;
                        if (!take_lease(ev)) begin
                            restart();
                            return;
                        end
                        nxt.arm_rebind = 1'b1;
                        nxt.rebind_secs = lease;
                        nxt.send_request = 1'b1;
                    end
                end
                dcf_pkg::ST_CODE_REQUESTING: begin
                    if (ev.msg_type == dcf_pkg::MSG_ACK) begin
                        if (!take_lease(ev)) begin
                            restart();
                            return;
                        end
                        ip = leased;
                        if (ev.router_addr == 32'd0) begin
                            restart();
                            return;
                        end
                        gw = ev.router_addr;
                        t1 = ev.opt_flags[0] ? ev.t1_time : (lease >> 1);
                        if (t1 == 32'd0) t1 = 32'd1;
                        t2 = ev.opt_flags[1] ? ev.t2_time : seven_eighths_lease();
                        if (t2 == 32'd0) t2 = 32'd1;
                        bound = 1'b1;
                        st = dcf_pkg::ST_CODE_BOUND;
                        arm_both();
                    end else if (ev.msg_type == dcf_pkg::MSG_NAK) begin
                        restart();
                    end
                end
                dcf_pkg::ST_CODE_RENEWING: begin
                    if (ev.msg_type == dcf_pkg::MSG_ACK) begin
                        st = dcf_pkg::ST_CODE_BOUND;
                        if (!take_lease(ev)) begin
                            restart();
                            return;
                        end
                        t1 = half_lease();
                        t2 = seven_eighths_lease();
                        arm_both();
                    end else if (ev.msg_type == dcf_pkg::MSG_NAK) begin
                        restart();
                    end
                end
                dcf_pkg::ST_CODE_RELEASING: st = dcf_pkg::ST_CODE_INIT;
                default: ;
            endcase
        endfunction

        function void note_event(t_event ev);
            nxt = '0;
            if (enabled) begin
                case (ev.cmd)
                    dcf_pkg::CMD_START: start();
                    dcf_pkg::CMD_STOP:  stop(ev.keep);
                    dcf_pkg::CMD_RELEASE: begin
                        if (st == dcf_pkg::ST_CODE_SELECTING) begin
                            stop(1'b0);
                        end else if (st == dcf_pkg::ST_CODE_REQUESTING
                                     || st == dcf_pkg::ST_CODE_BOUND
                                     || st == dcf_pkg::ST_CODE_RENEWING) begin
                            if (!retry_release) begin
                                stop(1'b0);
                            end else begin
                                st = dcf_pkg::ST_CODE_RELEASING;
                                advance_xid();
                                nxt.send_request = 1'b1;
                            end
                        end
                    end
                    dcf_pkg::CMD_RX: receive(ev);
                    dcf_pkg::CMD_T1: begin
                        if (st == dcf_pkg::ST_CODE_BOUND) begin
                            advance_xid();
                            st = dcf_pkg::ST_CODE_RENEWING;
                            nxt.send_request = 1'b1;
                        end
                    end
                    dcf_pkg::CMD_T2: restart();
                    default: ;
                endcase
            end
            nxt.state_now = st;
            nxt.ip_addr = ip;
            nxt.gateway_addr = gw;
            nxt.established = bound;
            status_due.push_back(nxt);
        endfunction

        function void flag(string what, logic [31:0] want, logic [31:0] got);
            mismatches++;
            if (mismatches <= 10) $display("mismatch %s: expected %h, got %h", what, want, got);
        endfunction

        function void check_status(logic [143:0] beat);
            dcf_pkg::t_result e;
            if (status_due.size() == 0) begin
                flag("unexpected beat, state_now", 32'd0, 32'(beat[2:0]));
                return;
            end
            e = status_due.pop_front();
            if (beat[2:0] !== e.state_now) flag("state_now", 32'(e.state_now), 32'(beat[2:0]));
            if (beat[3] !== e.send_request) flag("send_request", 32'(e.send_request), 32'(beat[3]));
            if (beat[4] !== e.send_arp) flag("send_arp", 32'(e.send_arp), 32'(beat[4]));
            if (beat[36:5] !== e.ip_addr) flag("ip_addr", e.ip_addr, beat[36:5]);
            if (beat[68:37] !== e.gateway_addr) flag("gateway_addr", e.gateway_addr, beat[68:37]);
            if (beat[69] !== e.arm_renew) flag("arm_renew", 32'(e.arm_renew), 32'(beat[69]));
            if (beat[70] !== e.arm_rebind) flag("arm_rebind", 32'(e.arm_rebind), 32'(beat[70]));
            if (beat[102:71] !== e.renew_secs) flag("renew_secs", e.renew_secs, beat[102:71]);
            if (beat[134:103] !== e.rebind_secs) flag("rebind_secs", e.rebind_secs, beat[134:103]);
            if (beat[135] !== e.cancel_timers)
                flag("cancel_timers", 32'(e.cancel_timers), 32'(beat[135]));
            if (beat[136] !== e.established) flag("established", 32'(e.established), 32'(beat[136]));
            if (beat[137] !== e.restarted) flag("restarted", 32'(e.restarted), 32'(beat[137]));
            if (beat[143:138] !== 6'd0) flag("pad", 32'd0, 32'(beat[143:138]));
        endfunction
    endclass

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [263:0] s_axis_tdata = '0;
    logic [4:0]   s_axis_tuser = '0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [143:0] m_axis_tdata;
    logic         i_cfg_valid = 1'b0;
    logic         o_cfg_ready;
    logic [1:0]   i_cfg_index = dcf_pkg::CFG_ENABLE;
    logic [31:0]  i_cfg_data = '0;

    t_lease_tracker tracker = new();
    bit             tx_idle_on = 1'b1;
    bit             rx_idle_on = 1'b1;
    int             hold_requests = 0;

    dhcp_client_fsm_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always #6 i_clk = ~i_clk;

    function automatic logic [31:0] any_word();
        case ($urandom_range(7))
            0: return 32'd0;
            1: return 32'hFFFF_FFFF;
            2: return 32'($urandom_range(15));
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [31:0] live_word();
        logic [31:0] w;
        w = any_word();
        return (w == 32'd0) ? 32'd1 : w;
    endfunction

    function automatic t_event cmd_event(logic [2:0] c, logic keep);
        t_event ev;
        ev = '0;
        ev.cmd = c;
        ev.keep = keep;
        ev.rx_xid = tracker.xid;
        return ev;
    endfunction

    function automatic t_event msg_event(logic [1:0] kind, logic [31:0] yi, logic [31:0] sid,
                                         logic [31:0] lease, logic [31:0] router,
                                         logic [1:0] flags, logic [31:0] t1, logic [31:0] t2);
        t_event ev;
        ev.cmd = dcf_pkg::CMD_RX;
        ev.keep = 1'($urandom);
        ev.rx_xid = tracker.xid;
        ev.msg_type = kind;
        ev.your_addr = yi;
        ev.server_addr = $urandom;
        ev.server_id = sid;
        ev.lease_len = lease;
        ev.router_addr = router;
        ev.opt_flags = flags;
        ev.t1_time = t1;
        ev.t2_time = t2;
        return ev;
    endfunction

    // Mostly well-formed steps of a negotiation with random content, the rest noise.
    function automatic t_event next_event();
        t_event ev;
        int roll;
        roll = $urandom_range(99);
        ev.cmd = 3'($urandom_range(7));
        ev.keep = 1'($urandom);
        ev.rx_xid = ($urandom_range(3) == 0) ? $urandom : tracker.xid;
        ev.msg_type = 2'($urandom_range(3));
        ev.your_addr = any_word();
        ev.server_addr = any_word();
        ev.server_id = any_word();
        ev.lease_len = any_word();
        ev.router_addr = any_word();
        ev.opt_flags = 2'($urandom_range(3));
        ev.t1_time = any_word();
        ev.t2_time = any_word();
        if (roll < 18) return ev;
        ev.cmd = dcf_pkg::CMD_RX;
        ev.rx_xid = tracker.xid;
        ev.your_addr = live_word();
        ev.server_id = live_word();
        ev.lease_len = live_word();
        ev.router_addr = live_word();
        if ($urandom_range(11) == 0) begin
            case ($urandom_range(3))
                0: ev.your_addr = '0;
                1: ev.server_id = '0;
                2: ev.lease_len = '0;
                default: ev.router_addr = '0;
            endcase
        end
        case (tracker.st)
            dcf_pkg::ST_CODE_INIT:
                ev.cmd = (roll < 88) ? dcf_pkg::CMD_START : dcf_pkg::CMD_STOP;
            dcf_pkg::ST_CODE_SELECTING: begin
                if (roll < 88) ev.msg_type = dcf_pkg::MSG_OFFER;
                else if (roll < 95) ev.cmd = dcf_pkg::CMD_RELEASE;
                else ev.cmd = dcf_pkg::CMD_T2;
            end
            dcf_pkg::ST_CODE_REQUESTING: begin
                if (roll < 75) ev.msg_type = dcf_pkg::MSG_ACK;
                else if (roll < 85) ev.msg_type = dcf_pkg::MSG_NAK;
                else if (roll < 92) ev.cmd = dcf_pkg::CMD_RELEASE;
                else if (roll < 96) ev.cmd = dcf_pkg::CMD_T2;
                else ev.cmd = dcf_pkg::CMD_STOP;
            end
            dcf_pkg::ST_CODE_BOUND: begin
                if (roll < 65) ev.cmd = dcf_pkg::CMD_T1;
                else if (roll < 78) ev.cmd = dcf_pkg::CMD_RELEASE;
                else if (roll < 86) ev.cmd = dcf_pkg::CMD_T2;
                else if (roll < 92) ev.cmd = dcf_pkg::CMD_STOP;
            end
            dcf_pkg::ST_CODE_RENEWING: begin
                if (roll < 70) ev.msg_type = dcf_pkg::MSG_ACK;
                else if (roll < 80) ev.msg_type = dcf_pkg::MSG_NAK;
                else if (roll < 88) ev.cmd = dcf_pkg::CMD_RELEASE;
                else if (roll < 94) ev.cmd = dcf_pkg::CMD_T2;
                else ev.cmd = dcf_pkg::CMD_T1;
            end
            default: begin
                if (roll >= 85) ev.cmd = dcf_pkg::CMD_START;
                else if (roll >= 65) ev.cmd = dcf_pkg::CMD_STOP;
            end
        endcase
        return ev;
    endfunction

    task automatic send_event(input t_event ev);
        if (tx_idle_on && $urandom_range(99) < 25) begin
            s_axis_tvalid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < 25);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {5'd0, ev.t2_time, ev.t1_time, ev.opt_flags, ev.router_addr,
                          ev.lease_len, ev.server_id, ev.server_addr, ev.your_addr,
                          ev.rx_xid, ev.keep};
        s_axis_tuser  <= {ev.msg_type, ev.cmd};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        tracker.note_event(ev);
    endtask

    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        while (tracker.status_due.size() != 0) @(posedge i_clk);
    endtask

    task automatic load_settings(input logic enable, input logic retry, input logic [31:0] seed);
        logic [1:0]  regs [3];
        logic [31:0] vals [3];
        regs[0] = dcf_pkg::CFG_ENABLE;
        regs[1] = dcf_pkg::CFG_RETRY;
        regs[2] = dcf_pkg::CFG_SEED;
        vals[0] = {31'd0, enable};
        vals[1] = {31'd0, retry};
        vals[2] = seed;
        drain_results();
        for (int r = 0; r < 3; r++) begin
            i_cfg_valid <= 1'b1;
            i_cfg_index <= regs[r];
            i_cfg_data  <= vals[r];
            @(posedge i_clk);
            while (!o_cfg_ready) @(posedge i_clk);
            tracker.write_reg(regs[r], vals[r]);
        end
        i_cfg_valid <= 1'b0;
    endtask

    initial begin : result_sink
        int hold_left;
        int holds_seen;
        hold_left = 0;
        holds_seen = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && m_axis_tvalid && m_axis_tready) tracker.check_status(m_axis_tdata);
            if (holds_seen != hold_requests) begin
                holds_seen = hold_requests;
                hold_left = RX_HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= !rx_idle_on || ($urandom_range(99) >= 25);
            end
        end
    end

    initial begin : watchdog
        int cycle_count;
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("Regression FAIL");
        $finish;
    end

    initial begin : stimulus
        t_event ev;
        int phase_items;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_event(msg_event(dcf_pkg::MSG_OFFER, 32'h0A00_0002, 32'h0A00_0001, 32'd3600,
                             32'h0A00_0001, 2'd0, 32'd0, 32'd0));
        send_event(cmd_event(dcf_pkg::CMD_START, 1'b0));
        send_event(cmd_event(dcf_pkg::CMD_START, 1'b0));
        ev = msg_event(dcf_pkg::MSG_OFFER, 32'h0A00_0002, 32'h0A00_0001, 32'd3600,
                       32'h0A00_0001, 2'd0, 32'd0, 32'd0);
        ev.rx_xid = ~ev.rx_xid;
        send_event(ev);
        send_event(msg_event(dcf_pkg::MSG_OTHER, 32'h0A00_0002, 32'h0A00_0001, 32'd3600,
                             32'h0A00_0001, 2'd3, 32'd10, 32'd20));
        send_event(msg_event(dcf_pkg::MSG_OFFER, 32'h0A00_0002, 32'h0A00_0001, 32'd0,
                             32'h0A00_0001, 2'd0, 32'd0, 32'd0));
        send_event(msg_event(dcf_pkg::MSG_OFFER, '1, '1, '1, '1, 2'd3, '1, '1));
        send_event(msg_event(dcf_pkg::MSG_ACK, 32'hC0A8_0164, 32'hC0A8_0101, 32'd7200, 32'd0,
                             2'd0, 32'd0, 32'd0));
        send_event(msg_event(dcf_pkg::MSG_OFFER, 32'hC0A8_0164, 32'hC0A8_0101, 32'd7200,
                             32'hC0A8_0101, 2'd0, 32'd0, 32'd0));
        send_event(msg_event(dcf_pkg::MSG_NAK, 32'd0, 32'd0, 32'd0, 32'd0, 2'd0, 32'd0, 32'd0));
        send_event(msg_event(dcf_pkg::MSG_OFFER, 32'd1, 32'd1, 32'd1, 32'd1, 2'd0, 32'd0, 32'd0));
        send_event(msg_event(dcf_pkg::MSG_ACK, 32'd1, 32'd1, 32'd1, 32'd1, 2'd0, '1, '1));
        send_event(cmd_event(dcf_pkg::CMD_T1, 1'b0));
        send_event(msg_event(dcf_pkg::MSG_ACK, '1, '1, '1, '1, 2'd3, 32'd5, 32'd9));
        send_event(cmd_event(dcf_pkg::CMD_T1, 1'b1));
        send_event(msg_event(dcf_pkg::MSG_NAK, '1, '1, '1, '1, 2'd1, 32'd0, 32'd0));
        send_event(msg_event(dcf_pkg::MSG_OFFER, 32'hC0A8_0164, 32'hC0A8_0101, 32'd8,
                             32'hC0A8_0101, 2'd0, 32'd0, 32'd0));
        send_event(msg_event(dcf_pkg::MSG_ACK, 32'hC0A8_0164, 32'hC0A8_0101, 32'd8,
                             32'hC0A8_0101, 2'd3, 32'd0, '1));
        send_event(cmd_event(CMD_SPARE_6, 1'b1));
        send_event(cmd_event(CMD_SPARE_7, 1'b0));
        send_event(cmd_event(dcf_pkg::CMD_STOP, 1'b1));
        send_event(cmd_event(dcf_pkg::CMD_START, 1'b0));
        send_event(msg_event(dcf_pkg::MSG_ACK, 32'hC0A8_0164, 32'd0, 32'd7200, 32'hC0A8_0101,
                             2'd0, 32'd0, 32'd0));
        send_event(msg_event(dcf_pkg::MSG_OFFER, 32'd0, 32'hC0A8_0101, 32'd7200, 32'hC0A8_0101,
                             2'd0, 32'd0, 32'd0));
        send_event(cmd_event(dcf_pkg::CMD_T2, 1'b0));

        for (int p = 0; p < 6; p++) begin
            case (p)
                0: load_settings(1'b1, 1'b0, 32'hFFFF_FFFF);
                1: load_settings(1'b1, 1'b1, $urandom);
                2: load_settings(1'b0, 1'b1, 32'd1);
                3: load_settings(1'b1, 1'b1, 32'd0);
                4: load_settings(1'b1, 1'b0, 32'd1);
                default: begin
                    load_settings(1'b1, 1'b1, $urandom);
                    tx_idle_on = 1'b0;
                    rx_idle_on <= 1'b0;
                end
            endcase
            phase_items = (p == 2) ? 40 : 360;
            for (int n = 0; n < phase_items; n++) begin
                // hold the result side off while input keeps coming, later pause input
                if (p == 4 && n == 120) hold_requests <= hold_requests + 1;
                if (p == 4 && n == 240) drain_results();
                send_event(next_event());
            end
        end

        drain_results();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (tracker.mismatches == 0 && tracker.status_due.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
